@@ hw/rtl/drst_pkg.sv @@
// Shared types and codes for the disjoint rectangle set tracker.
package drst_pkg;

    // Action codes carried in the input beat.
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_CHECK = 2'd1;
    localparam logic [1:0] ACT_ADD   = 2'd2;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned COUNT_W = 5;

    typedef struct packed {
        logic [1:0]                 action;
        logic signed [COORD_W-1:0]  left_x;
        logic signed [COORD_W-1:0]  bottom_y;
        logic signed [COORD_W-1:0]  right_x;
        logic signed [COORD_W-1:0]  top_y;
    } in_beat_t;

    typedef struct packed {
        logic                       no_overlap;
        logic                       overflow;
        logic [COUNT_W-1:0]         stored_count;
        logic signed [COORD_W-1:0]  bound_left;
        logic signed [COORD_W-1:0]  bound_bottom;
        logic signed [COORD_W-1:0]  bound_right;
        logic signed [COORD_W-1:0]  bound_top;
    } out_beat_t;

    // One stored rectangle: left, bottom, right (exclusive), top (exclusive).
    typedef struct packed {
        logic signed [COORD_W-1:0]  l;
        logic signed [COORD_W-1:0]  b;
        logic signed [COORD_W-1:0]  r;
        logic signed [COORD_W-1:0]  t;
    } rect_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } ctrl_state_t;

    // Strict overlap of half-open intervals in x and in y.
    function automatic logic rects_meet(input rect_t p, input rect_t q);
        rects_meet = ($signed(p.l) < $signed(q.r)) && ($signed(q.l) < $signed(p.r)) &&
                     ($signed(p.b) < $signed(q.t)) && ($signed(q.b) < $signed(p.t));
    endfunction

endpackage

@@ hw/rtl/disjoint_rect_set_tracker_unit.sv @@
// Top level of the disjoint rectangle set tracker: sequencer plus result register.
//
//  channel | direction | handshake          | beat type
//  --------+-----------+--------------------+---------------------
//  s_      | in        | s_valid / s_ready  | drst_pkg::in_beat_t
//  m_      | out       | m_valid / m_ready  | drst_pkg::out_beat_t
//
// Sequence: a clear beat goes straight from idle to the result; a check or add
// beat first scans the rectangles held when it arrives, at most MAX_RECTS. The
// scan reads one table entry per cycle through the single read port of the
// rectangle memory.
// Reset: aresetn is synchronous, active low; it empties the set, zeros the
// bounding box and drops any pending result. The table itself is not cleared.
// Stalls: a finished result waits in the output register while the next beat
// is taken and scanned; the sequencer holds its result only if that register
// is still full when the next result is ready.
module disjoint_rect_set_tracker_unit #(
    parameter int unsigned MAX_RECTS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  drst_pkg::in_beat_t   s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output drst_pkg::out_beat_t  m_payload
);

    logic                 out_valid_reg, out_valid_next;
    drst_pkg::out_beat_t  out_beat_reg, out_beat_next;
    logic                 slot_free;
    logic                 res_valid;
    drst_pkg::out_beat_t  res_beat;

    // The output register can take a new result when empty or draining now.
    assign slot_free = !out_valid_reg || m_ready;

    drst_ctrl #(
        .MAX_RECTS (MAX_RECTS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_beat   (s_payload),
        .slot_free (slot_free),
        .res_valid (res_valid),
        .res_beat  (res_beat)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        out_beat_next  = out_beat_reg;
        if (res_valid) begin
            // load the fresh result; the slot is free by construction
            out_valid_next = 1'b1;
            out_beat_next  = res_beat;
        end else if (m_ready) begin
            // drop the beat once the sink takes it
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_beat_reg <= out_beat_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_beat_reg;

`ifndef NO_ASSERTIONS
    // The sequencer never overwrites a result the sink has not taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> slot_free)
        else $error("result produced while output register is occupied");

    // One beat at a time: after an accept the input side is closed.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a beat is in flight");

    // Overflow only reports a full table.
    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_beat.overflow) |->
            (res_beat.stored_count == drst_pkg::COUNT_W'(MAX_RECTS)))
        else $error("overflow reported with table not full");

    // A result reaches the port the cycle after it is produced.
    a_result_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> m_valid)
        else $error("produced result did not appear on the output");
`endif

endmodule

@@ hw/rtl/drst_rect_mem.sv @@
// Rectangle table: single write port, one registered read port.
module drst_rect_mem #(
    parameter int unsigned MAX_RECTS = 16
) (
    input  logic                                      aclk,
    input  logic                                      rd_en,
    input  logic [(MAX_RECTS > 1 ? $clog2(MAX_RECTS) : 1)-1:0] rd_addr,
    output drst_pkg::rect_t                           rd_data,
    input  logic                                      wr_en,
    input  logic [(MAX_RECTS > 1 ? $clog2(MAX_RECTS) : 1)-1:0] wr_addr,
    input  drst_pkg::rect_t                           wr_data
);

    drst_pkg::rect_t mem [MAX_RECTS];
    drst_pkg::rect_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/drst_ctrl.sv @@
// Scan sequencer: walks the table, tracks count and bounding box, builds the result.
module drst_ctrl #(
    parameter int unsigned MAX_RECTS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  drst_pkg::in_beat_t     in_beat,
    input  logic                   slot_free,
    output logic                   res_valid,
    output drst_pkg::out_beat_t    res_beat
);

    localparam int unsigned CNT_W = $clog2(MAX_RECTS + 1);
    localparam int unsigned IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

    drst_pkg::ctrl_state_t state_reg, state_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  pend_reg, pend_next;
    logic                  hit_reg, hit_next;
    drst_pkg::rect_t       bbox_reg, bbox_next;
    drst_pkg::in_beat_t    item_reg, item_next;

    drst_pkg::rect_t       cur_rect;
    drst_pkg::rect_t       rd_data;
    logic                  rd_en;
    logic                  wr_en;
    logic                  is_add;
    logic                  is_clear;
    logic                  full;

    assign cur_rect = '{l: item_reg.left_x, b: item_reg.bottom_y,
                        r: item_reg.right_x, t: item_reg.top_y};
    assign is_clear = (item_reg.action == drst_pkg::ACT_CLEAR);
    assign is_add   = (item_reg.action == drst_pkg::ACT_ADD);
    assign full     = (count_reg >= CNT_W'(MAX_RECTS));

    drst_rect_mem #(
        .MAX_RECTS (MAX_RECTS)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (cur_rect)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= drst_pkg::ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            bbox_reg  <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            bbox_reg  <= bbox_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        hit_reg  <= hit_next;
        item_reg <= item_next;
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        pend_next  = 1'b0;
        hit_next   = hit_reg;
        bbox_next  = bbox_reg;
        item_next  = item_reg;
        in_ready   = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        res_valid  = 1'b0;

        case (state_reg)
            drst_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    item_next = in_beat;
                    idx_next  = '0;
                    hit_next  = 1'b0;
                    if (in_beat.action == drst_pkg::ACT_CLEAR) begin
                        state_next = drst_pkg::ST_DONE;
                    end else begin
                        state_next = drst_pkg::ST_SCAN;
                    end
                end
            end
            drst_pkg::ST_SCAN: begin
                // issue one read per cycle; compare the entry returned from last cycle
                rd_en     = (idx_reg < count_reg);
                pend_next = rd_en;
                if (rd_en) begin
                    idx_next = idx_reg + 1'b1;
                end
                if (pend_reg && drst_pkg::rects_meet(cur_rect, rd_data)) begin
                    hit_next = 1'b1;
                end
                if (!rd_en) begin
                    state_next = drst_pkg::ST_DONE;
                end
            end
            drst_pkg::ST_DONE: begin
                if (slot_free) begin
                    res_valid  = 1'b1;
                    state_next = drst_pkg::ST_IDLE;
                    if (is_clear) begin
                        count_next = '0;
                    end else if (is_add && !full) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (count_reg == '0) begin
                            bbox_next = cur_rect;
                        end else begin
                            if ($signed(cur_rect.l) < $signed(bbox_reg.l)) bbox_next.l = cur_rect.l;
                            if ($signed(cur_rect.b) < $signed(bbox_reg.b)) bbox_next.b = cur_rect.b;
                            if ($signed(cur_rect.r) > $signed(bbox_reg.r)) bbox_next.r = cur_rect.r;
                            if ($signed(cur_rect.t) > $signed(bbox_reg.t)) bbox_next.t = cur_rect.t;
                        end
                    end
                end
            end
            default: begin
                state_next = drst_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        res_beat.no_overlap   = !is_clear && !hit_reg;
        res_beat.overflow     = is_add && full;
        res_beat.stored_count = drst_pkg::COUNT_W'(count_next);
        res_beat.bound_left   = bbox_next.l;
        res_beat.bound_bottom = bbox_next.b;
        res_beat.bound_right  = bbox_next.r;
        res_beat.bound_top    = bbox_next.t;
    end

endmodule
